// File: rtl/spt_pkg.sv
// Shared types and constants for the stereo point triangulation block.
`default_nettype none

package spt_pkg;

   localparam int OUT_W   = 18;
   localparam int DISP_W  = 15;
   localparam int CSR_W   = 20;
   localparam int FB_W    = 36;
   localparam int YNUM_W  = 52;
   localparam int YDEN_W  = 36;

   typedef enum logic [2:0] {
      CSR_FOCAL_X  = 3'd0,
      CSR_FOCAL_Y  = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_BASELINE = 3'd4
   } csr_index_type;

   // Divider operands plus the sideband that travels beside them.
   typedef struct packed {
      logic              valid;
      logic              disp_ok;
      logic              x_neg;
      logic              y_neg;
      logic [15:0]       disp;
      logic [FB_W-1:0]   z_num;
      logic [31:0]       x_num;
      logic [YNUM_W-1:0] y_num;
      logic [YDEN_W-1:0] y_den;
   } front_type;

   typedef struct packed {
      logic        valid;
      logic        disp_ok;
      logic        x_neg;
      logic        y_neg;
      logic [15:0] disp;
   } side_type;

endpackage

`default_nettype wire

// File: rtl/spt_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none

module spt_divider
   import spt_pkg::*;
#(
   parameter int NW = 36,
   parameter int DW = 16,
   parameter int QW = 18
) (
   input  wire logic          clock,
   input  wire logic          advance,
   input  wire logic [NW-1:0] num_in,
   input  wire logic [DW-1:0] den_in,
   output logic      [QW-1:0] quot_out,
   output logic               ovf_out
);

   localparam int EW = (NW > DW + QW) ? NW : DW + QW;

   logic [EW-1:0] rem_ff [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic [QW-1:0] quot_ff [0:QW];
   logic          ovf_ff [0:QW];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= EW'(num_in);
         den_ff[0]  <= den_in;
         quot_ff[0] <= '0;
         // quotient would not fit in QW bits
         ovf_ff[0]  <= EW'(num_in) >= (EW'(den_in) << QW);
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      localparam int SH = QW - k;
      logic [EW-1:0] shifted;
      logic          fits;
      logic [EW-1:0] rem_in;
      logic [QW-1:0] quot_in;

      always_comb begin
         shifted = EW'(den_ff[k-1]) << SH;
         fits    = rem_ff[k-1] >= shifted;
         rem_in  = fits ? rem_ff[k-1] - shifted : rem_ff[k-1];
         quot_in = quot_ff[k-1] | (fits ? (QW'(1) << SH) : '0);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_ff[k-1];
            quot_ff[k] <= quot_in;
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   assign quot_out = quot_ff[QW];
   assign ovf_out  = ovf_ff[QW];

endmodule

`default_nettype wire

// File: rtl/spt_front.sv
// Front end: disparity, offsets and the products that feed the dividers.
`default_nettype none

module spt_front
   import spt_pkg::*;
#(
   parameter int FRAC_BITS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        in_valid,
   input  wire logic [15:0] left_x,
   input  wire logic [15:0] left_y,
   input  wire logic [15:0] right_x,
   input  wire logic [19:0] focal_x,
   input  wire logic [19:0] focal_y,
   input  wire logic [15:0] center_x,
   input  wire logic [15:0] center_y,
   input  wire logic [15:0] baseline,
   output front_type        front_out
);

   localparam logic [16:0] DISP_MIN = 17'(((1 << FRAC_BITS) + 9) / 10);
   localparam logic [31:0] DISP_MAX = 32'(1536 << FRAC_BITS);

   // stage 1
   logic              s1_valid_ff;
   logic              s1_ok_ff;
   logic [16:0]       s1_disp_ff;
   logic [16:0]       s1_dx_ff;
   logic [16:0]       s1_dy_ff;
   logic [FB_W-1:0]   s1_fb_ff;
   logic [16:0]       disp_in;
   logic              ok_in;

   // stage 2
   logic              s2_valid_ff;
   logic              s2_ok_ff;
   logic              s2_xneg_ff;
   logic              s2_yneg_ff;
   logic [15:0]       s2_disp_ff;
   logic [FB_W-1:0]   s2_fb_ff;
   logic [31:0]       s2_xnum_ff;
   logic [33:0]       s2_yhi_ff;
   logic [33:0]       s2_ylo_ff;
   logic [YDEN_W-1:0] s2_yden_ff;
   logic [15:0]       xmag;
   logic [15:0]       ymag;

   // stage 3
   front_type         s3_ff;
   front_type         s3_in;

   always_comb begin
      disp_in = {1'b0, left_x} - {1'b0, right_x};
      ok_in   = !disp_in[16] && (disp_in >= DISP_MIN) && (32'(disp_in) <= DISP_MAX)
                && (focal_y != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ok_ff   <= ok_in;
         s1_disp_ff <= disp_in;
         s1_dx_ff   <= {1'b0, left_x} - {1'b0, center_x};
         s1_dy_ff   <= {1'b0, left_y} - {1'b0, center_y};
         s1_fb_ff   <= FB_W'(focal_x) * FB_W'(baseline);
      end
   end

   always_comb begin
      xmag = s1_dx_ff[16] ? 16'(17'd0 - s1_dx_ff) : s1_dx_ff[15:0];
      ymag = s1_dy_ff[16] ? 16'(17'd0 - s1_dy_ff) : s1_dy_ff[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // split the wide y product into two 16x18 halves
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ok_ff   <= s1_ok_ff;
         s2_xneg_ff <= s1_dx_ff[16];
         s2_yneg_ff <= s1_dy_ff[16];
         s2_disp_ff <= s1_disp_ff[15:0];
         s2_fb_ff   <= s1_fb_ff;
         s2_xnum_ff <= 32'(xmag) * 32'(baseline);
         s2_yhi_ff  <= 34'(ymag) * 34'(s1_fb_ff[35:18]);
         s2_ylo_ff  <= 34'(ymag) * 34'(s1_fb_ff[17:0]);
         s2_yden_ff <= YDEN_W'(focal_y) * YDEN_W'(s1_disp_ff[15:0]);
      end
   end

   always_comb begin
      s3_in.valid   = s2_valid_ff;
      s3_in.disp_ok = s2_ok_ff;
      s3_in.x_neg   = s2_xneg_ff;
      s3_in.y_neg   = s2_yneg_ff;
      s3_in.disp    = s2_disp_ff;
      s3_in.z_num   = s2_fb_ff;
      s3_in.x_num   = s2_xnum_ff;
      s3_in.y_num   = (YNUM_W'(s2_yhi_ff) << 18) + YNUM_W'(s2_ylo_ff);
      s3_in.y_den   = s2_yden_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_ff.valid <= s3_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff.disp_ok <= s3_in.disp_ok;
         s3_ff.x_neg   <= s3_in.x_neg;
         s3_ff.y_neg   <= s3_in.y_neg;
         s3_ff.disp    <= s3_in.disp;
         s3_ff.z_num   <= s3_in.z_num;
         s3_ff.x_num   <= s3_in.x_num;
         s3_ff.y_num   <= s3_in.y_num;
         s3_ff.y_den   <= s3_in.y_den;
      end
   end

   assign front_out = s3_ff;

endmodule

`default_nettype wire

// File: rtl/stereo_point_triangulation.sv
// Top level of the stereo point triangulation pipeline.
`default_nettype none

// Rectified stereo triangulation: each transaction carries a matched point
// (left column and row, right column) and yields one result with the depth,
// lateral and vertical position in millimetres, truncated toward zero, or
// an all-zero result with point_valid low when the disparity or range
// checks fail. One transaction is taken every cycle unless a waiting result
// is stalled, which freezes the whole pipeline; each one passes through the
// three front stages, the bit-per-stage dividers and the output register.
// The user writes calibration registers through the csr port while no
// transaction is in flight; the block itself does not enforce this.
module stereo_point_triangulation
   import spt_pkg::*;
#(
   parameter int FRAC_BITS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [15:0]       req_left_x,
   input  wire logic [15:0]       req_left_y,
   input  wire logic [15:0]       req_right_x,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_point_valid,
   output logic signed [OUT_W-1:0] rsp_x_mm,
   output logic signed [OUT_W-1:0] rsp_y_mm,
   output logic [OUT_W-1:0]       rsp_z_mm,
   output logic [DISP_W-1:0]      rsp_disparity_px,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_data
);

   localparam int ZMAX_I = 10000 << FRAC_BITS;
   localparam int QW     = ($clog2(ZMAX_I + 1) > OUT_W) ? $clog2(ZMAX_I + 1) : OUT_W;
   localparam int LAT    = QW + 1;
   localparam logic [QW-1:0] Z_MIN  = QW'(100 << FRAC_BITS);
   localparam logic [QW-1:0] Z_MAX  = QW'(ZMAX_I);
   localparam logic [QW-1:0] XY_MAX = QW'(5000 << FRAC_BITS);

   logic [19:0] focal_x_ff;
   logic [19:0] focal_y_ff;
   logic [15:0] center_x_ff;
   logic [15:0] center_y_ff;
   logic [15:0] baseline_ff;

   logic        advance;
   front_type   front;
   side_type    side_ff [0:LAT-1];
   side_type    side_out;
   logic [QW-1:0] z_quot;
   logic [QW-1:0] x_quot;
   logic [QW-1:0] y_quot;
   logic        z_ovf;
   logic        x_ovf;
   logic        y_ovf;
   logic        ok;
   logic [QW:0] x_signed;
   logic [QW:0] y_signed;

   logic                 rsp_valid_ff;
   logic                 point_valid_ff;
   logic [OUT_W-1:0]     x_ff;
   logic [OUT_W-1:0]     y_ff;
   logic [OUT_W-1:0]     z_ff;
   logic [DISP_W-1:0]    disp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= 20'd16000;
         focal_y_ff  <= 20'd16000;
         center_x_ff <= 16'd10240;
         center_y_ff <= 16'd7680;
         baseline_ff <= 16'd1600;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_FOCAL_X:  focal_x_ff  <= csr_data;
            CSR_FOCAL_Y:  focal_y_ff  <= csr_data;
            CSR_CENTER_X: center_x_ff <= csr_data[15:0];
            CSR_CENTER_Y: center_y_ff <= csr_data[15:0];
            CSR_BASELINE: baseline_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // hold everything while a finished result waits
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   spt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .left_x    (req_left_x),
      .left_y    (req_left_y),
      .right_x   (req_right_x),
      .focal_x   (focal_x_ff),
      .focal_y   (focal_y_ff),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .baseline  (baseline_ff),
      .front_out (front)
   );

   spt_divider #(.NW(FB_W), .DW(16), .QW(QW)) u_div_z (
      .clock    (clock),
      .advance  (advance),
      .num_in   (front.z_num),
      .den_in   (front.disp),
      .quot_out (z_quot),
      .ovf_out  (z_ovf)
   );

   spt_divider #(.NW(32), .DW(16), .QW(QW)) u_div_x (
      .clock    (clock),
      .advance  (advance),
      .num_in   (front.x_num),
      .den_in   (front.disp),
      .quot_out (x_quot),
      .ovf_out  (x_ovf)
   );

   spt_divider #(.NW(YNUM_W), .DW(YDEN_W), .QW(QW)) u_div_y (
      .clock    (clock),
      .advance  (advance),
      .num_in   (front.y_num),
      .den_in   (front.y_den),
      .quot_out (y_quot),
      .ovf_out  (y_ovf)
   );

   // sideband delay line matching the divider depth
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         side_ff[0].valid   <= front.valid;
         side_ff[0].disp_ok <= front.disp_ok;
         side_ff[0].x_neg   <= front.x_neg;
         side_ff[0].y_neg   <= front.y_neg;
         side_ff[0].disp    <= front.disp;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign side_out = side_ff[LAT-1];

   always_comb begin
      ok = side_out.disp_ok && !z_ovf && !x_ovf && !y_ovf
           && (z_quot >= Z_MIN) && (z_quot <= Z_MAX)
           && (x_quot <= XY_MAX) && (y_quot <= XY_MAX);
      x_signed = side_out.x_neg ? (QW + 1)'(0) - {1'b0, x_quot} : {1'b0, x_quot};
      y_signed = side_out.y_neg ? (QW + 1)'(0) - {1'b0, y_quot} : {1'b0, y_quot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         point_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff   <= side_out.valid;
         point_valid_ff <= side_out.valid && ok;
      end
   end

   // drop the numbers of a rejected point
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= ok ? x_signed[OUT_W-1:0] : '0;
         y_ff    <= ok ? y_signed[OUT_W-1:0] : '0;
         z_ff    <= ok ? z_quot[OUT_W-1:0] : '0;
         disp_ff <= ok ? side_out.disp[DISP_W-1:0] : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_point_valid  = point_valid_ff;
   assign rsp_x_mm         = x_ff;
   assign rsp_y_mm         = y_ff;
   assign rsp_z_mm         = z_ff;
   assign rsp_disparity_px = disp_ff;

`ifndef SYNTH
   a_point_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_point_valid |-> rsp_valid)
      else $error("point_valid set outside a result transaction");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_point_valid) |->
         (rsp_x_mm == '0 && rsp_y_mm == '0 && rsp_z_mm == '0 && rsp_disparity_px == '0))
      else $error("rejected point carries nonzero fields");

   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_point_valid) |-> (rsp_disparity_px != '0 && rsp_z_mm != '0))
      else $error("accepted point with zero disparity or depth");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("pipeline advanced while result stalled");
`endif

endmodule

`default_nettype wire
